### hdl/cffa_pkg.sv
// ---------------------------------------------------------------------------
// cffa_pkg
// Shared codes, field widths and control structs of the block allocator.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package cffa_pkg;

	localparam int COUNT_W  = 7;
	localparam int START_W  = 6;
	localparam int LEN_W    = 7;
	localparam int EIDX_W   = 5;
	localparam int USE_W    = 6;
	localparam int STATUS_W = 3;

	typedef enum logic [0:0] {
		OP_ALLOC = 1'b0,
		OP_READ  = 1'b1
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK        = 3'd0,
		ST_FULL      = 3'd1,
		ST_NO_SPACE  = 3'd2,
		ST_BAD_COUNT = 3'd3,
		ST_UNUSED    = 3'd4
	} status_t;

	typedef struct packed {
		logic               go;
		logic [COUNT_W-1:0] count;
	} scan_cmd_t;

	typedef struct packed {
		logic               done;
		logic               found;
		logic [START_W-1:0] start;
	} scan_res_t;

	typedef struct packed {
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   len;
	} entry_t;

endpackage

`default_nettype wire

### hdl/cffa_if.sv
// ---------------------------------------------------------------------------
// cffa_if
// Request and response channels of the block allocator (valid/ready).
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface cffa_req_if;
	logic       valid;
	logic       ready;
	logic [0:0] operation;
	logic [6:0] block_count;
	logic [4:0] entry_index;

	modport source (output valid, output operation, output block_count,
		output entry_index, input ready);
	modport sink (input valid, input operation, input block_count,
		input entry_index, output ready);
endinterface

interface cffa_rsp_if;
	logic       valid;
	logic       ready;
	logic [2:0] status;
	logic [5:0] start_block;
	logic [6:0] run_length;
	logic [4:0] table_index;
	logic [5:0] entries_in_use;

	modport source (output valid, output status, output start_block,
		output run_length, output table_index, output entries_in_use, input ready);
	modport sink (input valid, input status, input start_block,
		input run_length, input table_index, input entries_in_use, output ready);
endinterface

`default_nettype wire

### hdl/contiguous_first_fit_block_allocator.sv
// Allocate: a serial search of the block map (one map bit per cycle), then a registered result.
// Read of a table entry: the result comes from the registered table read.
// One item in flight; a finished result waits in the output register while
// the next item is accepted.
// Reset clears the block map and the entry count; table contents are
// undefined until written and need no clearing pass.
// ---------------------------------------------------------------------------
// contiguous_first_fit_block_allocator
// First-fit contiguous block allocator with an allocation table.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module contiguous_first_fit_block_allocator #(
	parameter int NUM_BLOCKS    = 64,
	parameter int TABLE_ENTRIES = 32
) (
	input logic        clk,
	input logic        arst_n,
	cffa_req_if.sink   req,
	cffa_rsp_if.source rsp
);
	import cffa_pkg::*;

	localparam int CNT_W  = $clog2(TABLE_ENTRIES + 1);
	localparam int TIDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CMP_W  = (CNT_W > EIDX_W) ? CNT_W : EIDX_W;

	typedef enum logic [2:0] {
		S_IDLE = 3'b001,
		S_SCAN = 3'b010,
		S_FIN  = 3'b100
	} state_t;

	state_t             state_q;
	logic [CNT_W-1:0]   cnt_q;
	op_t                op_q;
	status_t            pend_status_q;
	logic [EIDX_W-1:0]  idx_q;
	logic [COUNT_W-1:0] n_q;

	logic               out_valid_q;
	status_t            out_status_q;
	logic [START_W-1:0] out_start_q;
	logic [LEN_W-1:0]   out_len_q;
	logic [EIDX_W-1:0]  out_tidx_q;
	logic [USE_W-1:0]   out_use_q;

	logic      req_acc;
	logic      is_read;
	status_t   acc_status;
	status_t   fin_status;
	logic      out_free;
	logic      fin;
	logic      tbl_we;
	entry_t    wr_data;
	entry_t    rd_data;
	scan_cmd_t scan_cmd;
	scan_res_t scan_res;

	assign req.ready = state_q == S_IDLE;
	assign req_acc   = req.valid && req.ready;
	assign is_read   = op_t'(req.operation) == OP_READ;

	always_comb begin
		if (is_read) begin
			acc_status = (CMP_W'(req.entry_index) >= CMP_W'(cnt_q)) ? ST_UNUSED : ST_OK;
		end else if (cnt_q == CNT_W'(TABLE_ENTRIES)) begin
			acc_status = ST_FULL;
		end else if (req.block_count == '0 ||
			req.block_count > COUNT_W'(NUM_BLOCKS)) begin
			acc_status = ST_BAD_COUNT;
		end else begin
			acc_status = ST_OK;
		end
	end

	assign scan_cmd.go    = req_acc && !is_read && acc_status == ST_OK;
	assign scan_cmd.count = req.block_count;

	cffa_scan #(
		.NUM_BLOCKS(NUM_BLOCKS)
	) u_scan (
		.clk   (clk),
		.arst_n(arst_n),
		.cmd   (scan_cmd),
		.res   (scan_res)
	);

	assign out_free = !out_valid_q || rsp.ready;
	assign fin      = (state_q == S_FIN) && out_free;

	always_comb begin
		if (pend_status_q != ST_OK) begin
			fin_status = pend_status_q;
		end else if (op_q == OP_READ || scan_res.found) begin
			fin_status = ST_OK;
		end else begin
			fin_status = ST_NO_SPACE;
		end
	end

	assign tbl_we        = fin && op_q == OP_ALLOC && fin_status == ST_OK;
	assign wr_data.start = scan_res.start;
	assign wr_data.len   = n_q;

	cffa_table #(
		.DEPTH(TABLE_ENTRIES),
		.AW   (TIDX_W)
	) u_table (
		.clk    (clk),
		.wr_en  (tbl_we),
		.wr_addr(TIDX_W'(cnt_q)),
		.wr_data(wr_data),
		.rd_en  (req_acc && is_read),
		.rd_addr(TIDX_W'(req.entry_index)),
		.rd_data(rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (req_acc) begin
						state_q <= scan_cmd.go ? S_SCAN : S_FIN;
					end
				end
				S_SCAN: begin
					if (scan_res.done) begin
						state_q <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
			if (tbl_we) begin
				cnt_q <= cnt_q + CNT_W'(1);
			end
			if (fin) begin
				out_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_acc) begin
			op_q          <= op_t'(req.operation);
			pend_status_q <= acc_status;
			idx_q         <= req.entry_index;
			n_q           <= req.block_count;
		end
		if (fin) begin
			out_status_q <= fin_status;
			out_use_q    <= USE_W'(tbl_we ? cnt_q + CNT_W'(1) : cnt_q);
			if (fin_status != ST_OK) begin
				out_start_q <= '0;
				out_len_q   <= '0;
				out_tidx_q  <= '0;
			end else if (op_q == OP_READ) begin
				out_start_q <= rd_data.start;
				out_len_q   <= rd_data.len;
				out_tidx_q  <= idx_q;
			end else begin
				out_start_q <= scan_res.start;
				out_len_q   <= '0;
				out_tidx_q  <= EIDX_W'(cnt_q);
			end
		end
	end

	assign rsp.valid          = out_valid_q;
	assign rsp.status         = out_status_q;
	assign rsp.start_block    = out_start_q;
	assign rsp.run_length     = out_len_q;
	assign rsp.table_index    = out_tidx_q;
	assign rsp.entries_in_use = out_use_q;

`ifndef SYNTHESIS
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CNT_W'(TABLE_ENTRIES))
		else $error("entry count above table size");
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q != $past(cnt_q)) |-> $past(tbl_we))
		else $error("entry count moved without a table write");
	a_done_in_scan: assert property (@(posedge clk) disable iff (!arst_n)
		scan_res.done |-> state_q == S_SCAN)
		else $error("search finished outside scan state");
`endif

endmodule

`default_nettype wire

### hdl/cffa_table.sv
// ---------------------------------------------------------------------------
// cffa_table
// Allocation table: one write port, one registered read port.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cffa_table #(
	parameter int DEPTH = 32,
	parameter int AW    = 5
) (
	input  logic                  clk,
	input  logic                  wr_en,
	input  logic [AW-1:0]         wr_addr,
	input  cffa_pkg::entry_t      wr_data,
	input  logic                  rd_en,
	input  logic [AW-1:0]         rd_addr,
	output cffa_pkg::entry_t      rd_data
);
	import cffa_pkg::*;

	entry_t mem_q [DEPTH];
	entry_t rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

`default_nettype wire

### hdl/cffa_scan.sv
// ---------------------------------------------------------------------------
// cffa_scan
// Holds the used-block map; bit-serial first-fit search over a rotating map.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module cffa_scan #(
	parameter int NUM_BLOCKS = 64
) (
	input  logic                clk,
	input  logic                arst_n,
	input  cffa_pkg::scan_cmd_t cmd,
	output cffa_pkg::scan_res_t res
);
	import cffa_pkg::*;

	localparam int POS_W = $clog2(NUM_BLOCKS);

	typedef enum logic [1:0] {
		SC_IDLE = 2'b01,
		SC_RUN  = 2'b10
	} sc_state_t;

	sc_state_t             state_q;
	logic [NUM_BLOCKS-1:0] map_q;
	logic [NUM_BLOCKS-1:0] top_mask;
	logic [POS_W-1:0]      pos_q;
	logic [COUNT_W-1:0]    run_q;
	logic [COUNT_W-1:0]    n_q;
	logic [START_W-1:0]    rstart_q;
	logic [START_W-1:0]    start_q;
	logic                  found_q;
	logic                  hit;
	logic                  last;

	// top n positions: where the run just passed sits after this rotation
	always_comb begin
		for (int i = 0; i < NUM_BLOCKS; i++) begin
			top_mask[i] = ({1'b0, n_q} + 8'(i)) >= 8'(NUM_BLOCKS);
		end
	end

	assign hit  = (state_q == SC_RUN) && !found_q && !map_q[0] &&
		((run_q + COUNT_W'(1)) == n_q);
	assign last = pos_q == POS_W'(NUM_BLOCKS - 1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= SC_IDLE;
			map_q    <= '0;
			pos_q    <= '0;
			run_q    <= '0;
			n_q      <= '0;
			rstart_q <= '0;
			start_q  <= '0;
			found_q  <= 1'b0;
		end else begin
			unique case (state_q)
				SC_IDLE: begin
					if (cmd.go) begin
						state_q  <= SC_RUN;
						pos_q    <= '0;
						run_q    <= '0;
						rstart_q <= '0;
						found_q  <= 1'b0;
						n_q      <= cmd.count;
					end
				end
				SC_RUN: begin
					map_q <= {map_q[0], map_q[NUM_BLOCKS-1:1]} |
						(hit ? top_mask : '0);
					pos_q <= pos_q + POS_W'(1);
					if (!found_q) begin
						if (map_q[0]) begin
							run_q    <= '0;
							rstart_q <= START_W'(pos_q) + START_W'(1);
						end else begin
							run_q <= run_q + COUNT_W'(1);
							if (hit) begin
								found_q <= 1'b1;
								start_q <= rstart_q;
							end
						end
					end
					if (last) begin
						state_q <= SC_IDLE;
					end
				end
				default: begin
					state_q <= SC_IDLE;
				end
			endcase
		end
	end

	assign res.done  = (state_q == SC_RUN) && last;
	assign res.found = found_q;
	assign res.start = start_q;

`ifndef SYNTHESIS
	a_map_grows: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(map_q) >= $past($countones(map_q)))
		else $error("used block count dropped");
	a_run_fits: assert property (@(posedge clk) disable iff (!arst_n)
		found_q |-> ({2'b0, start_q} + {1'b0, n_q}) <= 8'(NUM_BLOCKS))
		else $error("found run runs past the map");
	a_go_idle: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.go |-> state_q == SC_IDLE)
		else $error("search started while busy");
`endif

endmodule

`default_nettype wire

### dv/tb_contiguous_first_fit_block_allocator.sv
// ---------------------------------------------------------------------------
// tb_contiguous_first_fit_block_allocator
// Self-checking bench for the first-fit block allocator. A short scripted
// sequence covers reset reads, rejected counts, the largest count and
// requests just past the free space. Random traffic then fills the table,
// keeps the block map from running out first and goes on past a full table.
// Responses are checked against script values or an in-bench map/table model.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_contiguous_first_fit_block_allocator;

	import cffa_pkg::*;

	localparam int NUM_BLOCKS    = 64;
	localparam int TABLE_ENTRIES = 32;
	localparam int RANDOM_ITEMS  = 1000;
	localparam int SCRIPT_ROWS   = 16;

	typedef struct packed {
		status_t            status;
		logic [START_W-1:0] start;
		logic [LEN_W-1:0]   len;
		logic [EIDX_W-1:0]  idx;
		logic [USE_W-1:0]   in_use;
	} alloc_rsp_t;

	typedef struct packed {
		op_t                op;
		logic [COUNT_W-1:0] count;
		logic [EIDX_W-1:0]  idx;
		logic               hand;
		alloc_rsp_t         want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	cffa_req_if req_if ();
	cffa_rsp_if rsp_if ();

	contiguous_first_fit_block_allocator #(
		.NUM_BLOCKS   (NUM_BLOCKS),
		.TABLE_ENTRIES(TABLE_ENTRIES)
	) u_dut (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (req_if),
		.rsp   (rsp_if)
	);

	logic [NUM_BLOCKS-1:0] used_map;
	logic [START_W-1:0]    run_start [TABLE_ENTRIES];
	logic [LEN_W-1:0]      run_len   [TABLE_ENTRIES];
	int                    live_entries;

	alloc_rsp_t pending_results [$];
	int         mismatches;
	bit         calm;

	stim_row_t script [SCRIPT_ROWS] = '{
		'{OP_READ,  7'd0,   5'd0,  1'b1, '{ST_UNUSED,    6'd0, 7'd0, 5'd0, 6'd0}},
		'{OP_READ,  7'd0,   5'd31, 1'b1, '{ST_UNUSED,    6'd0, 7'd0, 5'd0, 6'd0}},
		'{OP_ALLOC, 7'd0,   5'd0,  1'b1, '{ST_BAD_COUNT, 6'd0, 7'd0, 5'd0, 6'd0}},
		'{OP_ALLOC, 7'd65,  5'd31, 1'b1, '{ST_BAD_COUNT, 6'd0, 7'd0, 5'd0, 6'd0}},
		'{OP_ALLOC, 7'd127, 5'd0,  1'b1, '{ST_BAD_COUNT, 6'd0, 7'd0, 5'd0, 6'd0}},
		'{OP_ALLOC, 7'd1,   5'd0,  1'b1, '{ST_OK,        6'd0, 7'd0, 5'd0, 6'd1}},
		'{OP_READ,  7'd127, 5'd0,  1'b1, '{ST_OK,        6'd0, 7'd1, 5'd0, 6'd1}},
		'{OP_READ,  7'd0,   5'd1,  1'b1, '{ST_UNUSED,    6'd0, 7'd0, 5'd0, 6'd1}},
		'{OP_ALLOC, 7'd64,  5'd0,  1'b1, '{ST_NO_SPACE,  6'd0, 7'd0, 5'd0, 6'd1}},
		'{OP_ALLOC, 7'd2,   5'd0,  1'b0, '0},
		'{OP_ALLOC, 7'd21,  5'd31, 1'b0, '0},
		'{OP_ALLOC, 7'd42,  5'd0,  1'b0, '0},
		'{OP_READ,  7'd0,   5'd2,  1'b0, '0},
		'{OP_READ,  7'd127, 5'd1,  1'b0, '0},
		'{OP_READ,  7'd0,   5'd31, 1'b1, '{ST_UNUSED,    6'd0, 7'd0, 5'd0, 6'd3}},
		'{OP_ALLOC, 7'd41,  5'd0,  1'b0, '0}
	};

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	initial begin
		#5_000_000;
		$display("[contiguous_first_fit_block_allocator] ERROR");
		$finish;
	end

	// first-fit outcome of one request; a successful allocate updates the map and the table
	function automatic alloc_rsp_t allocator_outcome(op_t op, logic [COUNT_W-1:0] cnt,
			logic [EIDX_W-1:0] idx);
		alloc_rsp_t            r;
		logic [NUM_BLOCKS-1:0] mask;
		int                    first;
		r = '0;
		r.status = ST_OK;
		first = -1;
		if (op == OP_READ) begin
			if (idx >= live_entries) begin
				r.status = ST_UNUSED;
			end else begin
				r.start = run_start[idx];
				r.len   = run_len[idx];
				r.idx   = idx;
			end
		end else if (live_entries >= TABLE_ENTRIES) begin
			r.status = ST_FULL;
		end else if (cnt == 0 || cnt > NUM_BLOCKS) begin
			r.status = ST_BAD_COUNT;
		end else begin
			mask = (cnt >= NUM_BLOCKS) ? '1 : ((64'd1 << cnt) - 64'd1);
			for (int s = 0; s + cnt <= NUM_BLOCKS && first < 0; s++) begin
				if (((used_map >> s) & mask) == '0)
					first = s;
			end
			if (first < 0) begin
				r.status = ST_NO_SPACE;
			end else begin
				used_map                = used_map | (mask << first);
				run_start[live_entries] = first[START_W-1:0];
				run_len[live_entries]   = cnt;
				r.start                 = first[START_W-1:0];
				r.idx                   = live_entries[EIDX_W-1:0];
				live_entries++;
			end
		end
		r.in_use = live_entries[USE_W-1:0];
		return r;
	endfunction

	task automatic issue(input op_t op, input logic [COUNT_W-1:0] cnt,
			input logic [EIDX_W-1:0] idx, input bit hand, input alloc_rsp_t want);
		alloc_rsp_t predicted;
		bit         taken;
		while (!calm && $urandom_range(99) < 27) begin
			req_if.valid <= 1'b0;
			@(posedge clk);
		end
		req_if.valid       <= 1'b1;
		req_if.operation   <= op;
		req_if.block_count <= cnt;
		req_if.entry_index <= idx;
		do begin
			@(negedge clk);
			taken = req_if.ready;
			@(posedge clk);
		end while (!taken);
		predicted = allocator_outcome(op, cnt, idx);
		pending_results.push_back(hand ? want : predicted);
	endtask

	task automatic flag_mismatch(input string what, input alloc_rsp_t want,
			input alloc_rsp_t got);
		mismatches++;
		if (mismatches <= 10) begin
			$write("%0t mismatch (%s): exp st=%0d start=%0d len=%0d idx=%0d use=%0d",
				$realtime, what, want.status, want.start, want.len, want.idx, want.in_use);
			$display(", got st=%0d start=%0d len=%0d idx=%0d use=%0d",
				got.status, got.start, got.len, got.idx, got.in_use);
		end
	endtask

	always @(negedge clk) begin : check_rsp
		alloc_rsp_t got;
		alloc_rsp_t want;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got.status = status_t'(rsp_if.status);
			got.start  = rsp_if.start_block;
			got.len    = rsp_if.run_length;
			got.idx    = rsp_if.table_index;
			got.in_use = rsp_if.entries_in_use;
			if (pending_results.size() == 0) begin
				flag_mismatch("unexpected item", '0, got);
			end else begin
				want = pending_results.pop_front();
				if (got !== want)
					flag_mismatch("field", want, got);
			end
		end
	end

	initial begin
		rsp_if.ready <= 1'b0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			rsp_if.ready <= calm || ($urandom_range(99) >= 27);
		end
	end

	initial begin : stimulus
		op_t              op;
		logic [COUNT_W-1:0] cnt;
		logic [EIDX_W-1:0]  idx;
		int               free;
		int               spare;
		int               pick;
		used_map     = '0;
		live_entries = 0;
		mismatches   = 0;
		calm         = 1'b0;
		arst_n       = 1'b0;
		req_if.valid       <= 1'b0;
		req_if.operation   <= OP_ALLOC;
		req_if.block_count <= '0;
		req_if.entry_index <= '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (script[i])
			issue(script[i].op, script[i].count, script[i].idx, script[i].hand,
				script[i].want);

		// hold off until the block has drained
		req_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);

		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			calm = (n >= 400 && n < 600);
			cnt  = COUNT_W'($urandom);
			idx  = EIDX_W'($urandom);
			if ($urandom_range(99) < 40) begin
				op = OP_READ;
			end else begin
				op    = OP_ALLOC;
				free  = NUM_BLOCKS - $countones(used_map);
				spare = free - (TABLE_ENTRIES - live_entries);
				pick  = $urandom_range(99);
				if (pick < 10)
					cnt = $urandom_range(1) ? '0 : COUNT_W'($urandom_range(127, 65));
				else if (pick < 25 && free < NUM_BLOCKS)
					cnt = COUNT_W'($urandom_range(NUM_BLOCKS, free + 1));
				else if (spare > 0)
					cnt = COUNT_W'(1 + $urandom_range(spare > 3 ? 3 : spare));
				else
					cnt = 7'd1;
			end
			issue(op, cnt, idx, 1'b0, '0);
		end
		calm = 1'b0;

		req_if.valid <= 1'b0;
		@(posedge clk);
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (80) @(posedge clk);
		if (mismatches == 0 && pending_results.size() == 0)
			$display("[contiguous_first_fit_block_allocator] OK");
		else
			$display("[contiguous_first_fit_block_allocator] ERROR");
		$finish;
	end

endmodule
